FILE: rtl/next_fit_slot_allocator_with_handle_maps_macros.svh
// Assertion macros for the next-fit slot allocator.
// NFSA_ASSERT checks a property on every clock edge outside reset.
// NFSA_ASSERT_NEXT checks that prop holds in the cycle after cond.
`ifndef NEXT_FIT_SLOT_ALLOCATOR_WITH_HANDLE_MAPS_MACROS_SVH
`define NEXT_FIT_SLOT_ALLOCATOR_WITH_HANDLE_MAPS_MACROS_SVH
`ifndef SYNTHESIS
`define NFSA_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("slot allocator assertion failed");
`define NFSA_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("slot allocator assertion failed");
`else
`define NFSA_ASSERT(label, clk, rst_n, prop)
`define NFSA_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

FILE: rtl/nfsa_pkg.sv
`default_nettype none

package nfsa_pkg;

	// Default sizes
	localparam int POOL_SLOTS_DEF     = 2048;
	localparam int SERVER_HANDLES_DEF = 1024;
	localparam int CLIENT_HANDLES_DEF = 1152;
	localparam int LOCAL_CLIENTS_DEF  = 1;

	// Port field widths
	localparam int REQ_W        = 3;
	localparam int HANDLE_W     = 11;
	localparam int LC_W         = 1;
	localparam int SLOT_PORT_W  = 11;
	localparam int STATUS_W     = 2;
	localparam int COUNT_PORT_W = 11;

	// Used-slot bitmap word geometry
	localparam int WORD_BITS = 64;
	localparam int BIT_W     = 6;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_SRV_CREATE = 3'd0;
	localparam logic [REQ_W-1:0] REQ_CLI_CREATE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SRV_FREE   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_CLI_FREE   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SRV_LOOKUP = 3'd4;
	localparam logic [REQ_W-1:0] REQ_CLI_LOOKUP = 3'd5;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNMAPPED  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD       = 2'd3;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_MAP,
		S_FREE,
		S_SCAN,
		S_DONE
	} state_t;

	// Handle map port control
	typedef struct packed {
		logic rd;
		logic wr;
		logic clear;
		logic client;
	} map_ctl_t;

	function automatic int clog2_min1(input int n);
		return (n > 2) ? $clog2(n) : 1;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/nfsa_scan.sv
`default_nettype none

// Find the lowest clear bit of a bitmap word between bit lo and bit hi.
module nfsa_scan (
	input  logic [nfsa_pkg::WORD_BITS-1:0] word,
	input  logic [nfsa_pkg::BIT_W-1:0]     lo,
	input  logic [nfsa_pkg::BIT_W-1:0]     hi,
	output logic                           found,
	output logic [nfsa_pkg::BIT_W-1:0]     idx
);

	localparam int WB = nfsa_pkg::WORD_BITS;
	localparam int BW = nfsa_pkg::BIT_W;

	logic [WB-1:0] ge_mask;
	logic [WB-1:0] le_mask;
	logic [WB-1:0] cand;
	logic [WB-1:0] iso;

	// Build the window and the free candidates inside it
	assign ge_mask = {WB{1'b1}} << lo;
	assign le_mask = {WB{1'b1}} >> (BW'(WB - 1) - hi);
	assign cand    = ~word & ge_mask & le_mask;
	assign iso     = cand & (~cand + WB'(1));
	assign found   = |cand;

	// Encode the isolated lowest candidate
	always_comb begin
		idx = '0;
		for (int i = 0; i < WB; i++) begin
			if (iso[i]) begin
				idx = idx | BW'(i);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/nfsa_maps.sv
`default_nettype none

// Server and client handle-to-slot maps, one shared access port.
module nfsa_maps #(
	parameter int SERVER_HANDLES = nfsa_pkg::SERVER_HANDLES_DEF,
	parameter int CLIENT_ENTRIES = nfsa_pkg::CLIENT_HANDLES_DEF,
	parameter int SLOT_W         = 11,
	parameter int MAP_AW         = 11,
	parameter int CLR_W          = 11
) (
	input  logic                clk,
	input  nfsa_pkg::map_ctl_t  ctl,
	input  logic [MAP_AW-1:0]   addr,
	input  logic [SLOT_W-1:0]   wdata,
	input  logic [CLR_W-1:0]    clr_idx,
	output logic [SLOT_W-1:0]   rdata
);

	localparam int SRV_AW = nfsa_pkg::clog2_min1(SERVER_HANDLES);
	localparam int CLI_AW = nfsa_pkg::clog2_min1(CLIENT_ENTRIES);

	logic [SLOT_W-1:0] srv_mem [SERVER_HANDLES];
	logic [SLOT_W-1:0] cli_mem [CLIENT_ENTRIES];
	logic [SLOT_W-1:0] srv_rd_q;
	logic [SLOT_W-1:0] cli_rd_q;
	logic              sel_client_q;

	// Write: clearing sweep or a single entry update
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			if (32'(clr_idx) < SERVER_HANDLES) begin
				srv_mem[clr_idx[SRV_AW-1:0]] <= '0;
			end
			if (32'(clr_idx) < CLIENT_ENTRIES) begin
				cli_mem[clr_idx[CLI_AW-1:0]] <= '0;
			end
		end else if (ctl.wr) begin
			if (ctl.client) begin
				cli_mem[addr[CLI_AW-1:0]] <= wdata;
			end else begin
				srv_mem[addr[SRV_AW-1:0]] <= wdata;
			end
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			srv_rd_q     <= srv_mem[addr[SRV_AW-1:0]];
			cli_rd_q     <= cli_mem[addr[CLI_AW-1:0]];
			sel_client_q <= ctl.client;
		end
	end

	assign rdata = sel_client_q ? cli_rd_q : srv_rd_q;

endmodule

`default_nettype wire

FILE: rtl/next_fit_slot_allocator_with_handle_maps.sv
`default_nettype none
`include "next_fit_slot_allocator_with_handle_maps_macros.svh"

// Channel   Handshake              Payload
// req       req_valid/req_ready    req_type, handle, local_client
// rsp       rsp_valid/rsp_ready    slot, status, free_count
//
// Create scans up to NW+1 64-bit bitmap words, one per cycle through the scan unit, NW
// being 32 at the default pool. Free runs through decode, map, free and done, lookup or a
// free of an unmapped handle through decode, map and done, a bad request through decode
// and done. After reset clr_q walks max(SERVER_HANDLES, LOCAL_CLIENTS*CLIENT_HANDLES, NW)
// indices (1152 by default) to zero the maps and bitmap; req_ready stays low meanwhile.
// One item at a time; a result waiting on rsp_ready holds the next item in its last step.
module next_fit_slot_allocator_with_handle_maps #(
	parameter int POOL_SLOTS     = nfsa_pkg::POOL_SLOTS_DEF,
	parameter int SERVER_HANDLES = nfsa_pkg::SERVER_HANDLES_DEF,
	parameter int CLIENT_HANDLES = nfsa_pkg::CLIENT_HANDLES_DEF,
	parameter int LOCAL_CLIENTS  = nfsa_pkg::LOCAL_CLIENTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [nfsa_pkg::REQ_W-1:0]        req_type,
	input  logic [nfsa_pkg::HANDLE_W-1:0]     handle,
	input  logic [nfsa_pkg::LC_W-1:0]         local_client,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic [nfsa_pkg::SLOT_PORT_W-1:0]  slot,
	output logic [nfsa_pkg::STATUS_W-1:0]     status,
	output logic [nfsa_pkg::COUNT_PORT_W-1:0] free_count
);

	localparam int WB             = nfsa_pkg::WORD_BITS;
	localparam int BW             = nfsa_pkg::BIT_W;
	localparam int SLOT_OUT_W     = nfsa_pkg::SLOT_PORT_W;
	localparam int COUNT_OUT_W    = nfsa_pkg::COUNT_PORT_W;
	localparam int SLOT_W         = nfsa_pkg::clog2_min1(POOL_SLOTS);
	localparam int NW             = (POOL_SLOTS + WB - 1) / WB;
	localparam int WORD_AW        = nfsa_pkg::clog2_min1(NW);
	localparam int CLIENT_ENTRIES = LOCAL_CLIENTS * CLIENT_HANDLES;
	localparam int SRV_AW         = nfsa_pkg::clog2_min1(SERVER_HANDLES);
	localparam int CLI_AW         = nfsa_pkg::clog2_min1(CLIENT_ENTRIES);
	localparam int MAP_AW         = (SRV_AW > CLI_AW) ? SRV_AW : CLI_AW;
	localparam int CLR_N0         = (SERVER_HANDLES > CLIENT_ENTRIES) ?
		SERVER_HANDLES : CLIENT_ENTRIES;
	localparam int CLR_N          = (CLR_N0 > NW) ? CLR_N0 : NW;
	localparam int CLR_W          = nfsa_pkg::clog2_min1(CLR_N);
	localparam int LAST_HI        = (POOL_SLOTS - 1) % WB;

	nfsa_pkg::state_t state_q, state_d;

	// Control registers
	logic [CLR_W-1:0]   clr_q;
	logic [SLOT_W-1:0]  last_q;
	logic [SLOT_W-1:0]  free_q;
	logic [WORD_AW-1:0] w_q;
	logic               wrap_q;
	logic               rsp_valid_q;

	// Item and result registers
	logic [nfsa_pkg::REQ_W-1:0]    req_q;
	logic [nfsa_pkg::HANDLE_W-1:0] handle_q;
	logic [nfsa_pkg::LC_W-1:0]     lc_q;
	logic [SLOT_W-1:0]             mslot_q;
	logic [SLOT_W-1:0]             res_slot_q;
	logic [nfsa_pkg::STATUS_W-1:0] res_status_q;
	logic [SLOT_W-1:0]             rsp_slot_q;
	logic [nfsa_pkg::STATUS_W-1:0] rsp_status_q;
	logic [SLOT_W-1:0]             rsp_count_q;

	// Bitmap memory
	logic [WB-1:0]      bm_mem [NW];
	logic [WB-1:0]      bm_rdata_q;
	logic               bm_rd;
	logic [WORD_AW-1:0] bm_raddr;
	logic               bm_we;
	logic [WORD_AW-1:0] bm_waddr;
	logic [WB-1:0]      bm_wdata;

	// Map port
	nfsa_pkg::map_ctl_t map_ctl;
	logic [MAP_AW-1:0]  map_addr;
	logic [SLOT_W-1:0]  map_wdata;
	logic [SLOT_W-1:0]  map_rdata;

	// Decode
	logic              is_client;
	logic              op_create;
	logic              op_free;
	logic              op_lookup;
	logic              op_bad;
	logic              bad_index;
	logic [SRV_AW-1:0] srv_idx;
	logic [CLI_AW-1:0] cli_idx;

	// Scan window
	logic [SLOT_W:0]    start_x;
	logic               start_in;
	logic [WORD_AW-1:0] start_w;
	logic [BW-1:0]      start_bit;
	logic [WORD_AW-1:0] last_w;
	logic [BW-1:0]      last_bit;
	logic [BW-1:0]      scan_lo;
	logic [BW-1:0]      scan_hi;
	logic               scan_found;
	logic [BW-1:0]      scan_idx;
	logic               scan_end;
	logic [WORD_AW-1:0] w_next;
	logic               wrap_next;
	logic [SLOT_W-1:0]  found_slot;
	logic [SLOT_W-1:0]  free_dec;
	logic [WORD_AW-1:0] mslot_w;
	logic [BW-1:0]      mslot_bit;
	logic [WORD_AW-1:0] rd_slot_w;

	// Sequencer actions
	logic                          scan_init;
	logic                          scan_step;
	logic                          hold_ld;
	logic                          res_ld;
	logic [SLOT_W-1:0]             res_slot_d;
	logic [nfsa_pkg::STATUS_W-1:0] res_status_d;
	logic                          last_ld;
	logic                          free_inc;
	logic                          free_dec_en;
	logic                          rsp_ld;

	assign req_ready = (state_q == nfsa_pkg::S_IDLE);

	// Decode the held request
	always_comb begin
		is_client = 1'b0;
		op_create = 1'b0;
		op_free   = 1'b0;
		op_lookup = 1'b0;
		op_bad    = 1'b0;
		case (req_q)
			nfsa_pkg::REQ_SRV_CREATE: op_create = 1'b1;
			nfsa_pkg::REQ_CLI_CREATE: begin
				op_create = 1'b1;
				is_client = 1'b1;
			end
			nfsa_pkg::REQ_SRV_FREE: op_free = 1'b1;
			nfsa_pkg::REQ_CLI_FREE: begin
				op_free   = 1'b1;
				is_client = 1'b1;
			end
			nfsa_pkg::REQ_SRV_LOOKUP: op_lookup = 1'b1;
			nfsa_pkg::REQ_CLI_LOOKUP: begin
				op_lookup = 1'b1;
				is_client = 1'b1;
			end
			default: op_bad = 1'b1;
		endcase
	end

	assign bad_index = op_bad ||
		(is_client ? (32'(lc_q) >= LOCAL_CLIENTS || 32'(handle_q) >= CLIENT_HANDLES)
		           : (32'(handle_q) >= SERVER_HANDLES));
	assign srv_idx   = SRV_AW'(handle_q);
	assign cli_idx   = CLI_AW'(handle_q) + (lc_q != '0 ? CLI_AW'(CLIENT_HANDLES) : '0);
	assign map_addr  = is_client ? MAP_AW'(cli_idx) : MAP_AW'(srv_idx);

	// Next-fit window: from just past last_q to the top, then from 1 up to last_q
	assign start_x   = {1'b0, last_q} + (SLOT_W + 1)'(1);
	assign start_in  = (last_q != SLOT_W'(POOL_SLOTS - 1));
	assign start_w   = WORD_AW'(32'(start_x) >> BW);
	assign start_bit = BW'(32'(start_x));
	assign last_w    = WORD_AW'(32'(last_q) >> BW);
	assign last_bit  = BW'(32'(last_q));
	assign mslot_w   = WORD_AW'(32'(mslot_q) >> BW);
	assign mslot_bit = BW'(32'(mslot_q));
	assign rd_slot_w = WORD_AW'(32'(map_rdata) >> BW);

	always_comb begin
		if (!wrap_q) begin
			scan_lo = (w_q == start_w) ? start_bit : '0;
			scan_hi = (w_q == WORD_AW'(NW - 1)) ? BW'(LAST_HI) : '1;
		end else begin
			scan_lo = (w_q == '0) ? BW'(1) : '0;
			scan_hi = (w_q == last_w) ? last_bit : '1;
		end
	end

	nfsa_scan u_scan (
		.word  (bm_rdata_q),
		.lo    (scan_lo),
		.hi    (scan_hi),
		.found (scan_found),
		.idx   (scan_idx)
	);

	assign scan_end   = wrap_q && (w_q == last_w);
	assign wrap_next  = wrap_q || (w_q == WORD_AW'(NW - 1));
	assign w_next     = (!wrap_q && w_q == WORD_AW'(NW - 1)) ? '0 : w_q + WORD_AW'(1);
	assign found_slot = SLOT_W'({w_q, scan_idx});
	assign free_dec   = (free_q != '0) ? free_q - SLOT_W'(1) : free_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			nfsa_pkg::S_CLEAR: begin
				if (clr_q == CLR_W'(CLR_N - 1)) begin
					state_d = nfsa_pkg::S_IDLE;
				end
			end
			nfsa_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = nfsa_pkg::S_DECODE;
				end
			end
			nfsa_pkg::S_DECODE: begin
				if (bad_index) begin
					state_d = nfsa_pkg::S_DONE;
				end else if (op_create) begin
					state_d = nfsa_pkg::S_SCAN;
				end else begin
					state_d = nfsa_pkg::S_MAP;
				end
			end
			nfsa_pkg::S_MAP: begin
				if (op_free && map_rdata != '0) begin
					state_d = nfsa_pkg::S_FREE;
				end else begin
					state_d = nfsa_pkg::S_DONE;
				end
			end
			nfsa_pkg::S_FREE: state_d = nfsa_pkg::S_DONE;
			nfsa_pkg::S_SCAN: begin
				if (scan_found || scan_end) begin
					state_d = nfsa_pkg::S_DONE;
				end
			end
			nfsa_pkg::S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = nfsa_pkg::S_IDLE;
				end
			end
			default: state_d = nfsa_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		bm_rd        = 1'b0;
		bm_raddr     = '0;
		bm_we        = 1'b0;
		bm_waddr     = '0;
		bm_wdata     = '0;
		map_ctl      = '0;
		map_wdata    = '0;
		scan_init    = 1'b0;
		scan_step    = 1'b0;
		hold_ld      = 1'b0;
		res_ld       = 1'b0;
		res_slot_d   = '0;
		res_status_d = nfsa_pkg::ST_OK;
		last_ld      = 1'b0;
		free_inc     = 1'b0;
		free_dec_en  = 1'b0;
		rsp_ld       = 1'b0;
		map_ctl.client = is_client;
		case (state_q)
			nfsa_pkg::S_CLEAR: begin
				bm_we         = (32'(clr_q) < NW);
				bm_waddr      = clr_q[WORD_AW-1:0];
				map_ctl.clear = 1'b1;
			end
			nfsa_pkg::S_DECODE: begin
				if (bad_index) begin
					res_ld       = 1'b1;
					res_status_d = nfsa_pkg::ST_BAD;
				end else if (op_create) begin
					bm_rd     = 1'b1;
					bm_raddr  = start_in ? start_w : '0;
					scan_init = 1'b1;
				end else begin
					map_ctl.rd = 1'b1;
				end
			end
			nfsa_pkg::S_MAP: begin
				if (op_lookup) begin
					res_ld       = 1'b1;
					res_slot_d   = map_rdata;
					res_status_d = (map_rdata == '0) ? nfsa_pkg::ST_UNMAPPED : nfsa_pkg::ST_OK;
				end else if (map_rdata == '0) begin
					res_ld       = 1'b1;
					res_status_d = nfsa_pkg::ST_UNMAPPED;
				end else begin
					map_ctl.wr = 1'b1;
					bm_rd      = 1'b1;
					bm_raddr   = rd_slot_w;
					hold_ld    = 1'b1;
				end
			end
			nfsa_pkg::S_FREE: begin
				res_ld     = 1'b1;
				res_slot_d = mslot_q;
				if (bm_rdata_q[mslot_bit]) begin
					bm_we    = 1'b1;
					bm_waddr = mslot_w;
					bm_wdata = bm_rdata_q & ~(WB'(1) << mslot_bit);
					free_inc = 1'b1;
				end
			end
			nfsa_pkg::S_SCAN: begin
				if (scan_found) begin
					bm_we        = 1'b1;
					bm_waddr     = w_q;
					bm_wdata     = bm_rdata_q | (WB'(1) << scan_idx);
					map_ctl.wr   = 1'b1;
					map_wdata    = found_slot;
					last_ld      = 1'b1;
					free_dec_en  = 1'b1;
					res_ld       = 1'b1;
					res_slot_d   = found_slot;
					res_status_d = (free_dec == '0) ? nfsa_pkg::ST_EXHAUSTED : nfsa_pkg::ST_OK;
				end else if (scan_end) begin
					map_ctl.wr   = 1'b1;
					res_ld       = 1'b1;
					res_status_d = (free_q == '0) ? nfsa_pkg::ST_EXHAUSTED : nfsa_pkg::ST_OK;
				end else begin
					bm_rd     = 1'b1;
					bm_raddr  = w_next;
					scan_step = 1'b1;
				end
			end
			nfsa_pkg::S_DONE: rsp_ld = !rsp_valid_q || rsp_ready;
			default: ;
		endcase
	end

	nfsa_maps #(
		.SERVER_HANDLES (SERVER_HANDLES),
		.CLIENT_ENTRIES (CLIENT_ENTRIES),
		.SLOT_W         (SLOT_W),
		.MAP_AW         (MAP_AW),
		.CLR_W          (CLR_W)
	) u_maps (
		.clk     (clk),
		.ctl     (map_ctl),
		.addr    (map_addr),
		.wdata   (map_wdata),
		.clr_idx (clr_q),
		.rdata   (map_rdata)
	);

	// Bitmap write and registered read
	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_waddr] <= bm_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (bm_rd) begin
			bm_rdata_q <= bm_mem[bm_raddr];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nfsa_pkg::S_CLEAR;
			clr_q       <= '0;
			last_q      <= SLOT_W'(1);
			free_q      <= SLOT_W'(POOL_SLOTS - 1);
			w_q         <= '0;
			wrap_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == nfsa_pkg::S_CLEAR) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			if (scan_init) begin
				w_q    <= start_in ? start_w : '0;
				wrap_q <= !start_in;
			end else if (scan_step) begin
				w_q    <= w_next;
				wrap_q <= wrap_next;
			end
			if (last_ld) begin
				last_q <= found_slot;
			end
			if (free_dec_en) begin
				free_q <= free_dec;
			end else if (free_inc && free_q != SLOT_W'(POOL_SLOTS - 1)) begin
				free_q <= free_q + SLOT_W'(1);
			end
			if (rsp_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the item, intermediate slot and result
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q    <= req_type;
			handle_q <= handle;
			lc_q     <= local_client;
		end
		if (hold_ld) begin
			mslot_q <= map_rdata;
		end
		if (res_ld) begin
			res_slot_q   <= res_slot_d;
			res_status_q <= res_status_d;
		end
		if (rsp_ld) begin
			rsp_slot_q   <= res_slot_q;
			rsp_status_q <= res_status_q;
			rsp_count_q  <= free_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign slot       = SLOT_OUT_W'(rsp_slot_q);
	assign status     = rsp_status_q;
	assign free_count = COUNT_OUT_W'(rsp_count_q);

	`NFSA_ASSERT_NEXT(a_alloc_takes_one, clk, arst_n, state_q == nfsa_pkg::S_SCAN && scan_found, free_q == $past(free_q) - SLOT_W'(1) || $past(free_q) == '0)
	`NFSA_ASSERT_NEXT(a_last_only_on_scan, clk, arst_n, state_q != nfsa_pkg::S_SCAN, $stable(last_q))
	`NFSA_ASSERT_NEXT(a_count_only_on_alloc_free, clk, arst_n, state_q != nfsa_pkg::S_SCAN && state_q != nfsa_pkg::S_FREE, $stable(free_q))
	`NFSA_ASSERT(a_exhausted_means_empty, clk, arst_n, rsp_valid && status == nfsa_pkg::ST_EXHAUSTED |-> free_count == '0)

endmodule

`default_nettype wire
